[hdl/hjbp_pkg.sv]
// Shared constants and control types of the hash join build and probe engine.
package hjbp_pkg;

  localparam int KEY_W = 32;
  localparam int CNT_W = 12;
  localparam int TOT_W = 48;
  localparam int BB_W = 4;
  localparam int SH_W = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;
  localparam int HV_W = 15;

  localparam int DEF_SLOTS = 2;
  localparam int DEF_MAX_BUCKETS = 1024;
  localparam int DEF_OVF_BUCKETS = 512;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_PROBE = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_BITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_SHIFT = 1'd1;

  typedef struct packed {
    logic latch;
    logic rd_head;
    logic ins_head;
    logic rd_ovf_head;
    logic rd_ovf_next;
    logic ins_ovf;
    logic alloc;
    logic cnt_head;
    logic cnt_ovf;
    logic clr_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       head_room;
    logic       head_linked;
    logic       ovf_room;
    logic       ovf_linked;
    logic       clr_last;
    logic       out_busy;
  } stat_t;

endpackage

[hdl/hjbp_if.sv]
// Word channels for input tuples and results.
interface hjbp_in_if;
  import hjbp_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [KEY_W-1:0] key;
  logic             last;
  modport source (output valid, output action, output key, output last, input ready);
  modport sink (input valid, input action, input key, input last, output ready);
endinterface

interface hjbp_out_if;
  import hjbp_pkg::*;
  logic             valid;
  logic             ready;
  logic             status;
  logic [CNT_W-1:0] match_count;
  logic [TOT_W-1:0] total_matches;
  modport source (output valid, output status, output match_count, output total_matches,
                  input ready);
  modport sink (input valid, input status, input match_count, input total_matches,
                output ready);
endinterface

[hdl/hash_join_build_probe.sv]
// Hash join build and probe engine, top level.
// An insert or probe word passes through three states for the head-index hash
// (mask, reciprocal multiply, modulo correction), a registered read of the head
// bucket, a state that acts on it and a state that loads the result register. The
// next word can be accepted in the cycle after the load. A probe also reads and
// counts each overflow bucket on the chain in turn. An insert that finds the head
// full and already linked also reads the linked overflow bucket. A clear action
// sweeps all MAX_BUCKETS entries of the head bucket memory one entry a cycle. The
// same sweep runs after reset, and no word is accepted during it (configuration
// writes are taken). A new word is accepted while the previous result still waits
// in the output register. The load of a result holds until that register is free.
module hash_join_build_probe
  import hjbp_pkg::*;
#(
  parameter int SLOTS_PER_BUCKET = DEF_SLOTS,
  parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
  parameter int OVERFLOW_BUCKETS = DEF_OVF_BUCKETS
) (
  input  logic                  clk,
  input  logic                  rst,
  hjbp_in_if.sink               tuple,
  hjbp_out_if.source            result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  hjbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tuple.valid),
    .in_action (tuple.action),
    .in_ready  (tuple.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hjbp_dp #(
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
    .MAX_BUCKETS      (MAX_BUCKETS),
    .OVERFLOW_BUCKETS (OVERFLOW_BUCKETS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_action  (tuple.action),
    .in_key     (tuple.key),
    .in_last    (tuple.last),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_status (result.status),
    .out_count  (result.match_count),
    .out_total  (result.total_matches)
  );

endmodule

[hdl/hjbp_ctrl.sv]
// Controller state machine of the hash join engine.
module hjbp_ctrl
  import hjbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  output logic       in_ready,
  input  stat_t      stat,
  output cmd_t       cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HASH1 = 4'd1;
  localparam logic [3:0] S_HASH2 = 4'd2;
  localparam logic [3:0] S_HASH3 = 4'd3;
  localparam logic [3:0] S_RDH   = 4'd4;
  localparam logic [3:0] S_HEAD  = 4'd5;
  localparam logic [3:0] S_OVF   = 4'd6;
  localparam logic [3:0] S_CLEAR = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state, state_next;
  logic       clr_result, clr_result_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    clr_result_next = clr_result;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (in_action) inside
            ACT_INSERT, ACT_PROBE: state_next = S_HASH1;
            ACT_CLEAR: begin
              state_next = S_CLEAR;
              clr_result_next = 1'b1;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_HASH1: state_next = S_HASH2;
      S_HASH2: state_next = S_HASH3;
      S_HASH3: state_next = S_RDH;
      S_RDH: begin
        cmd.rd_head = 1'b1;
        state_next = S_HEAD;
      end
      S_HEAD: begin
        if (stat.action == ACT_INSERT) begin
          if (stat.head_room) begin
            cmd.ins_head = 1'b1;
            state_next = S_DONE;
          end else if (stat.head_linked) begin
            cmd.rd_ovf_head = 1'b1;
            state_next = S_OVF;
          end else begin
            cmd.alloc = 1'b1;
            state_next = S_DONE;
          end
        end else begin
          cmd.cnt_head = 1'b1;
          if (stat.head_linked) begin
            cmd.rd_ovf_head = 1'b1;
            state_next = S_OVF;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_OVF: begin
        if (stat.action == ACT_INSERT) begin
          if (stat.ovf_room) cmd.ins_ovf = 1'b1;
          else cmd.alloc = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.cnt_ovf = 1'b1;
          if (stat.ovf_linked) cmd.rd_ovf_next = 1'b1;
          else state_next = S_DONE;
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = clr_result ? S_DONE : S_IDLE;
          clr_result_next = 1'b0;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_result <= 1'b0;
    end else begin
      state <= state_next;
      clr_result <= clr_result_next;
    end
  end

endmodule

[hdl/hjbp_dp.sv]
// Datapath of the hash join engine: hash, bucket memories, counters and result register.
module hjbp_dp
  import hjbp_pkg::*;
#(
  parameter int SLOTS_PER_BUCKET = DEF_SLOTS,
  parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
  parameter int OVERFLOW_BUCKETS = DEF_OVF_BUCKETS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            in_action,
  input  logic [KEY_W-1:0]      in_key,
  input  logic                  in_last,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_status,
  output logic [CNT_W-1:0]      out_count,
  output logic [TOT_W-1:0]      out_total
);

  localparam int HW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int LW = (OVERFLOW_BUCKETS > 1) ? $clog2(OVERFLOW_BUCKETS) : 1;
  localparam int PW = $clog2(OVERFLOW_BUCKETS + 1);
  localparam int FW = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int SW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / MAX_BUCKETS);
  localparam logic [16:0] MB = 17'(MAX_BUCKETS);
  localparam logic [FW-1:0] SLOTS_F = FW'(SLOTS_PER_BUCKET);
  localparam logic [PW-1:0] OVF_P = PW'(OVERFLOW_BUCKETS);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [TOT_W-1:0] TOT_MAX = '1;

  logic [BB_W-1:0] bucket_bits;
  logic [SH_W-1:0] hash_shift;

  logic [1:0]       action;
  logic [KEY_W-1:0] key;
  logic             last;

  logic [HV_W-1:0] hv;
  logic [47:0]     prod;
  logic [HV_W-1:0] qm;
  logic [HW-1:0]   h;
  logic [HV_W-1:0] hv_c;
  logic [HV_W-1:0] rem;

  logic [FW-1:0]    head_fill_mem [MAX_BUCKETS];
  logic [LW-1:0]    head_link_mem [MAX_BUCKETS];
  logic             head_lv_mem [MAX_BUCKETS];
  logic [KEY_W-1:0] head_keys [MAX_BUCKETS][SLOTS_PER_BUCKET];
  logic [FW-1:0]    ovf_fill_mem [OVERFLOW_BUCKETS];
  logic [LW-1:0]    ovf_link_mem [OVERFLOW_BUCKETS];
  logic             ovf_lv_mem [OVERFLOW_BUCKETS];
  logic [KEY_W-1:0] ovf_keys [OVERFLOW_BUCKETS][SLOTS_PER_BUCKET];

  logic [FW-1:0]    head_fill_q;
  logic [LW-1:0]    head_link_q;
  logic             head_lv_q;
  logic [KEY_W-1:0] head_row_q [SLOTS_PER_BUCKET];
  logic [FW-1:0]    ovf_fill_q;
  logic [LW-1:0]    ovf_link_q;
  logic             ovf_lv_q;
  logic [KEY_W-1:0] ovf_row_q [SLOTS_PER_BUCKET];
  logic [LW-1:0]    ovf_addr;
  logic [LW-1:0]    ovf_rd_addr;

  logic [HW-1:0] clr_idx;
  logic [PW-1:0] pool;
  logic          pool_full;
  logic          do_alloc;

  logic [CNT_W-1:0] count;
  logic             status;
  logic [TOT_W-1:0] total;
  logic [FW-1:0]    hits;
  logic [CNT_W:0]   cnt_sum;
  logic [TOT_W:0]   tot_sum;
  logic [TOT_W-1:0] tot_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_bits <= BB_W'(10);
      hash_shift <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BUCKET_BITS: bucket_bits <= cfg_data[BB_W-1:0];
        REG_HASH_SHIFT:  hash_shift <= cfg_data[SH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      action <= in_action;
      key <= in_key;
      last <= in_last;
    end
  end

  // Head index: shift and mask the key, then reduce modulo the bucket count by reciprocal multiply.
  assign hv_c = HV_W'((key >> hash_shift) & ((32'd1 << bucket_bits) - 32'd1));
  assign rem = hv - qm;

  always_ff @(posedge clk) begin
    hv <= hv_c;
    prod <= 48'(hv_c) * 48'(RECIP);
    qm <= HV_W'(17'(prod[47:32]) * MB);
    h <= (17'(rem) >= MB) ? HW'(17'(rem) - MB) : HW'(rem);
  end

  assign pool_full = (pool >= OVF_P);
  assign do_alloc = cmd.alloc && !pool_full;

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      head_fill_mem[clr_idx] <= '0;
      head_lv_mem[clr_idx] <= 1'b0;
    end else if (cmd.ins_head) begin
      head_fill_mem[h] <= head_fill_q + FW'(1);
    end else if (do_alloc) begin
      head_lv_mem[h] <= 1'b1;
      head_link_mem[h] <= pool[LW-1:0];
    end
    if (cmd.rd_head) begin
      head_fill_q <= head_fill_mem[h];
      head_link_q <= head_link_mem[h];
      head_lv_q <= head_lv_mem[h];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_head) head_keys[h][head_fill_q[SW-1:0]] <= key;
    if (cmd.rd_head) head_row_q <= head_keys[h];
  end

  assign ovf_rd_addr = cmd.rd_ovf_next ? ovf_link_q : head_link_q;

  always_ff @(posedge clk) begin
    if (cmd.ins_ovf) begin
      ovf_fill_mem[ovf_addr] <= ovf_fill_q + FW'(1);
    end else if (do_alloc) begin
      ovf_fill_mem[pool[LW-1:0]] <= FW'(1);
      ovf_lv_mem[pool[LW-1:0]] <= head_lv_q;
      ovf_link_mem[pool[LW-1:0]] <= head_lv_q ? head_link_q : '0;
    end
    if (cmd.rd_ovf_head || cmd.rd_ovf_next) begin
      ovf_fill_q <= ovf_fill_mem[ovf_rd_addr];
      ovf_link_q <= ovf_link_mem[ovf_rd_addr];
      ovf_lv_q <= ovf_lv_mem[ovf_rd_addr];
      ovf_addr <= ovf_rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_ovf) ovf_keys[ovf_addr][ovf_fill_q[SW-1:0]] <= key;
    else if (do_alloc) ovf_keys[pool[LW-1:0]][0] <= key;
    if (cmd.rd_ovf_head || cmd.rd_ovf_next) ovf_row_q <= ovf_keys[ovf_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      pool <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_idx <= stat.clr_last ? '0 : clr_idx + HW'(1);
        if (stat.clr_last) pool <= '0;
      end else if (do_alloc) begin
        pool <= pool + PW'(1);
      end
    end
  end

  always_comb begin
    hits = '0;
    for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
      if (cmd.cnt_ovf) begin
        if (FW'(i) < ovf_fill_q && ovf_row_q[i] == key) hits = hits + FW'(1);
      end else begin
        if (FW'(i) < head_fill_q && head_row_q[i] == key) hits = hits + FW'(1);
      end
    end
  end

  assign cnt_sum = (CNT_W+1)'(count) + (CNT_W+1)'(hits);
  assign tot_sum = (TOT_W+1)'(total) + (TOT_W+1)'(count);
  assign tot_new = tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      count <= '0;
      status <= 1'b0;
    end else begin
      if (cmd.cnt_head || cmd.cnt_ovf) count <= cnt_sum[CNT_W] ? CNT_MAX : cnt_sum[CNT_W-1:0];
      if (cmd.alloc && pool_full) status <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      total <= last ? '0 : tot_new;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= status;
      out_count <= count;
      out_total <= tot_new;
    end
  end

  always_comb begin
    stat.action = action;
    stat.head_room = head_fill_q < SLOTS_F;
    stat.head_linked = head_lv_q;
    stat.ovf_room = ovf_fill_q < SLOTS_F;
    stat.ovf_linked = ovf_lv_q;
    stat.clr_last = (clr_idx == HW'(MAX_BUCKETS - 1));
    stat.out_busy = out_valid && !out_ready;
  end

  a_pool_bound: assert property (@(posedge clk) disable iff (rst) pool <= OVF_P)
    else $error("overflow pool index past pool size");
  a_pool_take: assert property (@(posedge clk) disable iff (rst)
    do_alloc |=> pool == $past(pool) + PW'(1))
    else $error("allocation did not advance pool");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten while held");

endmodule

[bench/hjbp_checker.sv]
// Checker of the hash join engine: watches the channels, predicts each result and compares.
`timescale 1ns / 100ps

module hjbp_checker
  import hjbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  hjbp_in_if                    tuple,
  hjbp_out_if                   result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  localparam int NHEAD = DEF_MAX_BUCKETS;
  localparam int NOVF = DEF_OVF_BUCKETS;
  localparam int NSLOT = DEF_SLOTS;
  localparam logic [TOT_W-1:0] TOT_SAT = {TOT_W{1'b1}};

  typedef struct packed {
    logic             status;
    logic [CNT_W-1:0] match_count;
    logic [TOT_W-1:0] total_matches;
  } join_res_t;

  join_res_t join_res_q[$];

  int unsigned      head_cnt[NHEAD];
  logic [KEY_W-1:0] head_key[NHEAD*NSLOT];
  int unsigned      nxt_bucket[NHEAD+NOVF];
  bit               has_link[NHEAD+NOVF];
  int unsigned      ovf_cnt[NOVF];
  logic [KEY_W-1:0] ovf_key[NOVF*NSLOT];
  int unsigned      free_ptr;
  logic [TOT_W-1:0] run_total;
  logic [BB_W-1:0]  bkt_bits;
  logic [SH_W-1:0]  shift_amt;

  assign pending = join_res_q.size();

  function automatic int unsigned bucket_of(logic [KEY_W-1:0] k);
    logic [31:0] m;
    m = (32'd1 << bkt_bits) - 32'd1;
    return ((k >> shift_amt) & m) % NHEAD;
  endfunction

  function automatic void empty_table();
    for (int i = 0; i < NHEAD; i++) head_cnt[i] = 0;
    for (int i = 0; i < NHEAD + NOVF; i++) begin
      nxt_bucket[i] = 0;
      has_link[i] = 0;
    end
    for (int i = 0; i < NOVF; i++) ovf_cnt[i] = 0;
    free_ptr = 0;
  endfunction

  function automatic bit insert_key(logic [KEY_W-1:0] k);
    int unsigned h;
    int unsigned nb;
    int unsigned b;
    bit linked;
    h = bucket_of(k);
    if (head_cnt[h] < NSLOT) begin
      head_key[h*NSLOT + head_cnt[h]] = k;
      head_cnt[h]++;
      return 0;
    end
    linked = has_link[h];
    nb = nxt_bucket[h] % NOVF;
    if (linked && ovf_cnt[nb] < NSLOT) begin
      ovf_key[nb*NSLOT + ovf_cnt[nb]] = k;
      ovf_cnt[nb]++;
      return 0;
    end
    if (free_ptr >= NOVF) return 1;
    b = free_ptr;
    free_ptr++;
    has_link[NHEAD+b] = linked;
    nxt_bucket[NHEAD+b] = linked ? nb : 0;
    nxt_bucket[h] = b;
    has_link[h] = 1;
    ovf_cnt[b] = 1;
    ovf_key[b*NSLOT] = k;
    return 0;
  endfunction

  function automatic int unsigned count_matches(logic [KEY_W-1:0] k);
    int unsigned h;
    int unsigned b;
    int unsigned n;
    bit more;
    h = bucket_of(k);
    n = 0;
    for (int i = 0; i < head_cnt[h] && i < NSLOT; i++)
      if (head_key[h*NSLOT + i] == k) n++;
    more = has_link[h];
    b = nxt_bucket[h] % NOVF;
    for (int s = 0; more && s < NOVF; s++) begin
      for (int i = 0; i < ovf_cnt[b] && i < NSLOT; i++)
        if (ovf_key[b*NSLOT + i] == k) n++;
      more = has_link[NHEAD+b];
      b = nxt_bucket[NHEAD+b] % NOVF;
    end
    return n;
  endfunction

  function automatic join_res_t apply_tuple(logic [1:0] act, logic [KEY_W-1:0] k, logic lst);
    join_res_t r;
    int unsigned n;
    r = '0;
    if (act == ACT_INSERT) begin
      r.status = insert_key(k);
    end else if (act == ACT_PROBE) begin
      n = count_matches(k);
      if (n > 4095) n = 4095;
      r.match_count = n[CNT_W-1:0];
      if (run_total > TOT_SAT - TOT_W'(n)) run_total = TOT_SAT;
      else run_total = run_total + TOT_W'(n);
    end else if (act == ACT_CLEAR) begin
      empty_table();
    end
    r.total_matches = run_total;
    if (lst) run_total = '0;
    return r;
  endfunction

  always @(posedge clk) begin
    join_res_t want;
    if (rst) begin
      empty_table();
      run_total = '0;
      bkt_bits <= 4'd10;
      shift_amt <= '0;
      join_res_q.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BUCKET_BITS) bkt_bits <= cfg_data[BB_W-1:0];
        else if (cfg_index == REG_HASH_SHIFT) shift_amt <= cfg_data[SH_W-1:0];
      end
      if (tuple.valid && tuple.ready)
        join_res_q.push_back(apply_tuple(tuple.action, tuple.key, tuple.last));
      if (result.valid && result.ready) begin
        if (join_res_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d count=%0d total=%0d", $time,
                   result.status, result.match_count, result.total_matches);
          errors <= errors + 1;
        end else begin
          want = join_res_q.pop_front();
          if (want.status !== result.status ||
              want.match_count !== result.match_count ||
              want.total_matches !== result.total_matches) begin
            $display("%0t: mismatch expected status=%0d count=%0d total=%0d", $time,
                     want.status, want.match_count, want.total_matches);
            $display("%0t:          actual   status=%0d count=%0d total=%0d", $time,
                     result.status, result.match_count, result.total_matches);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

[bench/tb_hash_join_build_probe.sv]
// Testbench top of the hash join engine: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_hash_join_build_probe;
  import hjbp_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;
  int                    cycles;
  int                    rx_words;
  logic [KEY_W-1:0]      key_pool[16];

  hjbp_in_if  tuple_ch ();
  hjbp_out_if result_ch ();

  hash_join_build_probe i_dut (
    .clk       (clk),
    .rst       (rst),
    .tuple     (tuple_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hjbp_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .tuple     (tuple_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("hash_join_build_probe verification failed");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  // receive side, with one long hold-off early in the run
  initial begin
    int unsigned gap;
    result_ch.ready <= 1'b0;
    rx_words = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = (rx_words == 200) ? 600 : draw_gap();
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      rx_words++;
    end
  end

  task automatic send_word(logic [1:0] act, logic [KEY_W-1:0] k, logic lst);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      tuple_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tuple_ch.valid  <= 1'b1;
    tuple_ch.action <= act;
    tuple_ch.key    <= k;
    tuple_ch.last   <= lst;
    do @(posedge clk); while (!tuple_ch.ready);
  endtask

  task automatic drain();
    tuple_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(int unsigned bb, int unsigned sh);
    write_reg(REG_BUCKET_BITS, CFG_DATA_W'(bb));
    write_reg(REG_HASH_SHIFT, CFG_DATA_W'(sh));
  endtask

  task automatic refill_pool(int unsigned n);
    for (int i = 0; i < 16; i++)
      key_pool[i] = (i < n) ? $urandom() : key_pool[i % n];
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return key_pool[$urandom_range(0, 15)];
  endfunction

  task automatic random_phase(int unsigned n);
    int unsigned r;
    logic [1:0] act;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 47) act = ACT_INSERT;
      else if (r < 95) act = ACT_PROBE;
      else if (r < 97) act = ACT_CLEAR;
      else act = 2'd3;
      send_word(act, pick_key(), $urandom_range(0, 9) == 0);
    end
    drain();
  endtask

  initial begin
    tuple_ch.valid  <= 1'b0;
    tuple_ch.action <= ACT_INSERT;
    tuple_ch.key    <= '0;
    tuple_ch.last   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    set_config(10, 0);
    send_word(ACT_INSERT, 32'h0000_0000, 1'b0);
    send_word(ACT_INSERT, 32'hFFFF_FFFF, 1'b0);
    send_word(ACT_INSERT, 32'hFFFF_FFFF, 1'b0);
    send_word(ACT_INSERT, 32'hFFFF_FFFF, 1'b0);
    send_word(ACT_INSERT, 32'hFFFF_FFFF, 1'b0);
    send_word(ACT_INSERT, 32'h0000_03FF, 1'b0);
    send_word(ACT_INSERT, 32'h0000_03FF, 1'b0);
    send_word(ACT_INSERT, 32'h0000_03FF, 1'b0);
    send_word(ACT_PROBE, 32'hFFFF_FFFF, 1'b0);
    send_word(ACT_PROBE, 32'h0000_03FF, 1'b0);
    send_word(ACT_PROBE, 32'h0000_0000, 1'b1);
    send_word(ACT_PROBE, 32'h1234_5678, 1'b0);
    send_word(ACT_PROBE, 32'hFFFF_FFFF, 1'b0);
    send_word(2'd3, 32'hFFFF_FFFF, 1'b0);
    send_word(2'd3, 32'h0000_0000, 1'b1);
    send_word(ACT_CLEAR, 32'h0, 1'b0);
    send_word(ACT_PROBE, 32'hFFFF_FFFF, 1'b1);
    drain();

    set_config(15, 31);
    send_word(ACT_INSERT, 32'h8000_0000, 1'b0);
    send_word(ACT_INSERT, 32'h7FFF_FFFF, 1'b0);
    send_word(ACT_PROBE, 32'h8000_0000, 1'b0);
    send_word(ACT_PROBE, 32'h7FFF_FFFF, 1'b1);
    drain();

    // single bucket: exhaust the overflow pool
    set_config(0, $urandom_range(0, 31));
    refill_pool(8);
    for (int i = 0; i < 1040; i++)
      send_word(ACT_INSERT, key_pool[$urandom_range(0, 7)], $urandom_range(0, 19) == 0);
    for (int i = 0; i < 8; i++)
      send_word(ACT_PROBE, key_pool[i], i == 7);
    send_word(ACT_CLEAR, $urandom(), 1'b0);
    drain();

    set_config(15, 31);
    refill_pool(12);
    random_phase(100);
    set_config(10, 0);
    refill_pool(16);
    random_phase(100);
    set_config(1, $urandom_range(0, 31));
    refill_pool(6);
    random_phase(100);
    set_config($urandom_range(0, 15), $urandom_range(0, 31));
    refill_pool(10);
    random_phase(100);

    if (errors == 0) begin
      $display("hash_join_build_probe verification clean");
    end else begin
      $display("hash_join_build_probe verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/hjbp_pkg.sv
hdl/hjbp_if.sv
hdl/hjbp_ctrl.sv
hdl/hjbp_dp.sv
hdl/hash_join_build_probe.sv
bench/hjbp_checker.sv
bench/tb_hash_join_build_probe.sv
